### hdl/ipdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdf_pkg
// Shared types and constants for the response framer with data indications.
// ----------------------------------------------------------------------------
package ipdf_pkg;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 9;
    localparam int LEN_W   = 16;
    localparam int CAUSE_W = 3;
    localparam int PFX_LEN = 5;

    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;

    // end cause codes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_NEWLINE  = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_STOP     = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_PAYLOAD  = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_ZERO_LEN = 3'd4;
    localparam logic [CAUSE_W-1:0] CAUSE_FULL     = 3'd5;

    // configuration register indexes
    localparam logic REG_STOP_CHAR = 1'b0;
    localparam logic REG_MAX_LEN   = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic [7:0]         position;
        logic               data_record;
        logic               in_payload;
        logic [LEN_W-1:0]   payload_length;
        logic               record_end;
        logic [CAUSE_W-1:0] end_cause;
    } ipdf_result_t;

    // "+IPD," header prefix
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h2B;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h44;
            3'd4:    c = 8'h2C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### hdl/ipdf_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdf_in_stage
// Input register for received bytes; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module ipdf_in_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [ipdf_pkg::BYTE_W-1:0] s_byte,
    input  logic                       take,
    output logic                       q_valid,
    output logic [ipdf_pkg::BYTE_W-1:0] q_byte
);
    import ipdf_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;

    assign s_ready = !valid_reg || take;
    assign q_valid = valid_reg;
    assign q_byte  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            byte_reg <= s_byte;
        end
    end

endmodule

### hdl/ipdf_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdf_parse
// Per-record state and the one-byte framing step.
// ----------------------------------------------------------------------------
module ipdf_parse (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [ipdf_pkg::BYTE_W-1:0] rx_byte,
    input  logic [ipdf_pkg::BYTE_W-1:0] stop_char,
    input  logic [7:0]                  rec_limit,
    output logic                        emit,
    output ipdf_pkg::ipdf_result_t      res
);
    import ipdf_pkg::*;

    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic               pm_reg,    pm_next;
    logic               ipd_reg,   ipd_next;
    logic               dig_reg,   dig_next;
    logic               hdr_reg,   hdr_next;
    logic [LEN_W-1:0]   len_reg,   len_next;
    logic [LEN_W-1:0]   rem_reg,   rem_next;

    logic [CNT_W-1:0]   cnt_inc;
    logic [CAUSE_W-1:0] cause;
    logic               payload;
    logic               match;
    logic [19:0]        prod;

    assign emit    = (rx_byte != CHAR_CR);
    assign cnt_inc = cnt_reg + CNT_W'(1);

    always_comb begin
        pm_next  = pm_reg;
        ipd_next = ipd_reg;
        dig_next = dig_reg;
        hdr_next = hdr_reg;
        len_next = len_reg;
        rem_next = rem_reg;
        cause    = CAUSE_NONE;
        payload  = 1'b0;
        match    = 1'b0;
        prod     = 20'((20'(len_reg) << 3) + (20'(len_reg) << 1))
                   + 20'(rx_byte - CHAR_0);

        if (cnt_reg < CNT_W'(PFX_LEN)) begin
            match   = pm_reg && (rx_byte == prefix_char(cnt_reg[2:0]));
            pm_next = match;
            if (cnt_reg == CNT_W'(PFX_LEN - 1)) begin
                ipd_next = match;
            end
        end else if (ipd_reg && !hdr_reg) begin
            if (rx_byte == CHAR_COLON) begin
                hdr_next = 1'b1;
                rem_next = len_reg;
                if (len_reg == '0) begin
                    cause = CAUSE_ZERO_LEN;
                end
            end else if (dig_reg && rx_byte >= CHAR_0 && rx_byte <= CHAR_9) begin
                // saturate at the full 16-bit range
                len_next = (prod > 20'hFFFF) ? 16'hFFFF : prod[LEN_W-1:0];
            end else begin
                dig_next = 1'b0;
            end
        end else if (ipd_reg && hdr_reg && rem_reg != '0) begin
            payload  = 1'b1;
            rem_next = rem_reg - LEN_W'(1);
            if (rem_reg == LEN_W'(1)) begin
                cause = CAUSE_PAYLOAD;
            end
        end

        if (cause == CAUSE_NONE) begin
            if (rx_byte == CHAR_LF) begin
                cause = CAUSE_NEWLINE;
            end else if (stop_char != '0 && rx_byte == stop_char) begin
                cause = CAUSE_STOP;
            end else if (cnt_inc >= {1'b0, rec_limit}) begin
                cause = CAUSE_FULL;
            end
        end

        res.data           = rx_byte;
        res.position       = cnt_reg[7:0];
        res.data_record    = ipd_next;
        res.in_payload     = payload;
        res.payload_length = hdr_next ? len_next : '0;
        res.record_end     = (cause != CAUSE_NONE);
        res.end_cause      = cause;

        cnt_next = cnt_inc;
        if (cause != CAUSE_NONE) begin
            cnt_next = '0;
            pm_next  = 1'b1;
            ipd_next = 1'b0;
            dig_next = 1'b1;
            hdr_next = 1'b0;
            len_next = '0;
            rem_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            pm_reg  <= 1'b1;
            ipd_reg <= 1'b0;
            dig_reg <= 1'b1;
            hdr_reg <= 1'b0;
            len_reg <= '0;
            rem_reg <= '0;
        end else if (step && emit) begin
            cnt_reg <= cnt_next;
            pm_reg  <= pm_next;
            ipd_reg <= ipd_next;
            dig_reg <= dig_next;
            hdr_reg <= hdr_next;
            len_reg <= len_next;
            rem_reg <= rem_next;
        end
    end

endmodule

### hdl/ipdf_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipdf_out_stage
// Result register; holds a request until the sink takes it.
// ----------------------------------------------------------------------------
module ipdf_out_stage (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  ipdf_pkg::ipdf_result_t res_in,
    output logic                   free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output ipdf_pkg::ipdf_result_t res_out
);
    import ipdf_pkg::*;

    logic         valid_reg;
    ipdf_result_t res_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

### hdl/at_response_ipd_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// at_response_ipd_framer
// Frames a received byte stream into records and parses "+IPD," headers.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata[7:0] rx_byte
//  m_*       out  m_tvalid/m_tready   tdata: data, position, payload_length;
//                                     tuser: data_record, in_payload, end_cause
//  cfg_*     in   cfg_we              cfg_addr 0 stop_char, 1 max_len
//
//  Bytes pass through the input register and then the result register; one byte per cycle
//  sustained while the output is not stalled, as the framing step between the two registers is combinational.
//  Carriage returns are consumed without a result, even while m_tready is low.
//  Reset is synchronous on aresetn; no clearing pass is needed.
//  A stalled output still lets one more byte wait in the input register.
// ----------------------------------------------------------------------------
module at_response_ipd_framer #(
    parameter int MAX_RECORD = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] data, [15:8] position, [31:16] payload_length
    output logic        m_tlast,
    output logic [4:0]  m_tuser,    // [0] data_record, [1] in_payload, [4:2] end_cause
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [8:0]  cfg_wdata
);
    import ipdf_pkg::*;

    localparam int CAP_INT = (MAX_RECORD < 256) ? MAX_RECORD : 256;
    localparam logic [CNT_W-1:0] LEN_CAP = CNT_W'(CAP_INT);

    logic [BYTE_W-1:0] stop_char_reg;
    logic [7:0]        limit_reg;
    logic [CNT_W-1:0]  eff_len;

    logic              q_valid;
    logic [BYTE_W-1:0] q_byte;
    logic              take;
    logic              emit;
    logic              out_free;
    ipdf_result_t      res;
    ipdf_result_t      res_out;

    // record limit is max_len clamped, minus one; kept ready at write time
    always_comb begin
        eff_len = cfg_wdata;
        if (cfg_wdata < CNT_W'(2)) begin
            eff_len = CNT_W'(2);
        end else if (cfg_wdata > LEN_CAP) begin
            eff_len = LEN_CAP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_char_reg <= '0;
            limit_reg     <= 8'(LEN_CAP - CNT_W'(1));
        end else if (cfg_we) begin
            if (cfg_addr == REG_STOP_CHAR) begin
                stop_char_reg <= cfg_wdata[BYTE_W-1:0];
            end else if (cfg_addr == REG_MAX_LEN) begin
                limit_reg <= 8'(eff_len - CNT_W'(1));
            end
        end
    end

    assign take = q_valid && (!emit || out_free);

    ipdf_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_byte  (s_tdata),
        .take    (take),
        .q_valid (q_valid),
        .q_byte  (q_byte)
    );

    ipdf_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (take),
        .rx_byte   (q_byte),
        .stop_char (stop_char_reg),
        .rec_limit (limit_reg),
        .emit      (emit),
        .res       (res)
    );

    ipdf_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && emit),
        .res_in   (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_out  (res_out)
    );

    assign m_tdata = {res_out.payload_length, res_out.position, res_out.data};
    assign m_tlast = res_out.record_end;
    assign m_tuser = {res_out.end_cause, res_out.in_payload, res_out.data_record};

    // record end flag and cause code agree
    a_end_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser[4:2] != CAUSE_NONE)))
        else $error("record end flag and cause disagree");

    // carriage returns are never forwarded
    a_no_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] != CHAR_CR))
        else $error("carriage return reached the output");

    // payload bytes and parsed lengths only occur in data records
    a_payload_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1] || m_tdata[31:16] != '0) |-> m_tuser[0])
        else $error("payload data outside a data record");

    // a newly loaded result after a record end starts at position zero
    a_pos_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        take && emit && u_parse.cnt_reg == '0 |=> m_tdata[15:8] == 8'd0)
        else $error("record did not restart at position zero");

endmodule
